// ===== rtl/swbt_pkg.sv =====
// Shared types and constants for the stopwatch bank timer.
package swbt_pkg;

   // Command codes carried on the request mode field
   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_START   = 3'd1,
      MODE_RESTART = 3'd2,
      MODE_STOP    = 3'd3,
      MODE_CLEAR   = 3'd4,
      MODE_READ    = 3'd5
   } mode_type;

   localparam int NUM_COUNTERS_DEF     = 8;
   localparam int TICKS_PER_SECOND_DEF = 10;

   localparam int MODE_W    = 3;
   localparam int INDEX_W   = 3;
   localparam int COUNT_W   = 16;
   localparam int MINUTES_W = 11;
   localparam int GLOBAL_W  = 32;
   localparam int DIVIDER_W = 4;

   // Division by 60 as multiply by ceil(2^21 / 60) and shift right by 21;
   // exact for every 16-bit value.
   localparam int                  RECIP_W    = 16;
   localparam logic [RECIP_W-1:0]  RECIP_60   = 16'd34953;
   localparam int                  RECIP_SHIFT = 21;
   localparam int                  PROD_W     = COUNT_W + RECIP_W;

endpackage

// ===== rtl/swbt_div60.sv =====
// Divide-by-60 unit: registered reciprocal multiply, quotient taken by shift.
module swbt_div60
   import swbt_pkg::*;
(
   input  logic                 clock,
   input  logic                 load,
   input  logic [COUNT_W-1:0]   value,
   output logic [MINUTES_W-1:0] quotient
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   // one 16x16 product per load
   assign prod_in = PROD_W'(value) * PROD_W'(RECIP_60);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign quotient = prod_ff[RECIP_SHIFT +: MINUTES_W];

endmodule

// ===== rtl/stopwatch_bank_timer_unit.sv =====
// Top level of the stopwatch bank timer: command sequencer and counter bank.
//
// Usage:
//   The req_ channel takes one command per transaction: a tick (mode 0) or a
//   start, restart, stop, clear or read of the counter named by
//   req_clock_index. Every command returns exactly one transaction on the
//   rsp_ channel with the addressed counter, its whole minutes, the tenth and
//   second flags and the global seconds count, all as they stand after the
//   command. Modes 6 and 7 act as a read; an index past the last counter
//   changes nothing and reports zero seconds and minutes.
//   Timing: req_ready is high only while the sequencer is idle. An accepted
//   command passes through the divide and finish states before rsp_valid
//   rises, and a tick that completes a second first sweeps the running
//   counters, which advance one per cycle through one shared incrementer.
//   Minutes come from one registered reciprocal multiply.
//   The result sits in an output register, so the next command is accepted
//   while a result waits; a stalled receiver (rsp_ready low) holds the
//   sequencer before it writes the following result.
//   Reset (synchronous, active high) clears all counters, run bits, the tick
//   divider, both flags and the global count, and drops rsp_valid.
module stopwatch_bank_timer_unit
   import swbt_pkg::*;
#(
   parameter int NUM_COUNTERS     = NUM_COUNTERS_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [INDEX_W-1:0]   req_clock_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COUNT_W-1:0]   rsp_clock_seconds,
   output logic [MINUTES_W-1:0] rsp_clock_minutes,
   output logic                 rsp_tenth_flag,
   output logic                 rsp_second_flag,
   output logic [GLOBAL_W-1:0]  rsp_global_seconds
);

   localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [COUNT_W-1:0]       counter_ff [NUM_COUNTERS];
   logic [COUNT_W-1:0]       counter_in [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0]  run_ff, run_in;
   logic [DIVIDER_W-1:0]     divider_ff, divider_in;
   logic [DIVIDER_W-1:0]     divider_next;
   logic                     tenth_ff, tenth_in;
   logic                     second_ff, second_in;
   logic [GLOBAL_W-1:0]      global_ff, global_in;
   logic [INDEX_W-1:0]       index_ff, index_in;
   logic [IDX_W-1:0]         sweep_ff, sweep_in;
   logic [COUNT_W-1:0]       value_ff, value_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]       rsp_seconds_ff, rsp_seconds_in;
   logic [MINUTES_W-1:0]     rsp_minutes_ff, rsp_minutes_in;
   logic                     rsp_tenth_ff, rsp_tenth_in;
   logic                     rsp_second_ff, rsp_second_in;
   logic [GLOBAL_W-1:0]      rsp_global_ff, rsp_global_in;
   logic                     req_index_ok;
   logic                     held_index_ok;
   logic [IDX_W-1:0]         req_slot;
   logic [IDX_W-1:0]         held_slot;
   logic                     div_load;
   logic [MINUTES_W-1:0]     minutes;

   assign req_index_ok  = ({1'b0, req_clock_index} < (INDEX_W + 1)'(NUM_COUNTERS));
   assign held_index_ok = ({1'b0, index_ff} < (INDEX_W + 1)'(NUM_COUNTERS));
   assign req_slot      = IDX_W'(req_clock_index);
   assign held_slot     = IDX_W'(index_ff);
   assign divider_next  = divider_ff + DIVIDER_W'(1);

   // Sequencer next-state and datapath
   always_comb begin
      state_in       = state_ff;
      counter_in     = counter_ff;
      run_in         = run_ff;
      divider_in     = divider_ff;
      tenth_in       = tenth_ff;
      second_in      = second_ff;
      global_in      = global_ff;
      index_in       = index_ff;
      sweep_in       = sweep_ff;
      value_in       = value_ff;
      rsp_seconds_in = rsp_seconds_ff;
      rsp_minutes_in = rsp_minutes_ff;
      rsp_tenth_in   = rsp_tenth_ff;
      rsp_second_in  = rsp_second_ff;
      rsp_global_in  = rsp_global_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      div_load       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               index_in = req_clock_index;
               state_in = ST_DIVIDE;
               if (req_mode == MODE_TICK) begin
                  tenth_in = !tenth_ff;
                  if (divider_next >= DIVIDER_W'(TICKS_PER_SECOND)) begin
                     divider_in = '0;
                     second_in  = !second_ff;
                     global_in  = global_ff + GLOBAL_W'(1);
                     sweep_in   = '0;
                     state_in   = ST_SWEEP;
                  end else begin
                     divider_in = divider_next;
                  end
               end else if (req_index_ok) begin
                  case (req_mode)
                     MODE_START: begin
                        run_in[req_slot]     = 1'b1;
                        counter_in[req_slot] = '0;
                     end
                     MODE_RESTART: begin
                        run_in[req_slot] = 1'b1;
                     end
                     MODE_STOP: begin
                        run_in[req_slot] = 1'b0;
                     end
                     MODE_CLEAR: begin
                        counter_in[req_slot] = '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         // one counter per cycle through the shared incrementer
         ST_SWEEP: begin
            if (run_ff[sweep_ff]) begin
               counter_in[sweep_ff] = counter_ff[sweep_ff] + COUNT_W'(1);
            end
            if (sweep_ff == IDX_W'(NUM_COUNTERS - 1)) begin
               state_in = ST_DIVIDE;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
            end
         end

         // fetch the addressed counter and start the minutes multiply
         ST_DIVIDE: begin
            value_in = held_index_ok ? counter_ff[held_slot] : '0;
            div_load = 1'b1;
            state_in = ST_FINISH;
         end

         // load the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_seconds_in = value_ff;
               rsp_minutes_in = minutes;
               rsp_tenth_in   = tenth_ff;
               rsp_second_in  = second_ff;
               rsp_global_in  = global_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '{default: '0};
         run_ff       <= '0;
         divider_ff   <= '0;
         tenth_ff     <= 1'b0;
         second_ff    <= 1'b0;
         global_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         run_ff       <= run_in;
         divider_ff   <= divider_in;
         tenth_ff     <= tenth_in;
         second_ff    <= second_in;
         global_ff    <= global_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      index_ff       <= index_in;
      sweep_ff       <= sweep_in;
      value_ff       <= value_in;
      rsp_seconds_ff <= rsp_seconds_in;
      rsp_minutes_ff <= rsp_minutes_in;
      rsp_tenth_ff   <= rsp_tenth_in;
      rsp_second_ff  <= rsp_second_in;
      rsp_global_ff  <= rsp_global_in;
   end

   swbt_div60 u_div60 (
      .clock    (clock),
      .load     (div_load),
      .value    (value_in),
      .quotient (minutes)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clock_seconds  = rsp_seconds_ff;
   assign rsp_clock_minutes  = rsp_minutes_ff;
   assign rsp_tenth_flag     = rsp_tenth_ff;
   assign rsp_second_flag    = rsp_second_ff;
   assign rsp_global_seconds = rsp_global_ff;

endmodule
